// ===== hw/rtl/dnsa_pkg.sv =====
// Package with the constants, codes and types of the DNS response A-record extractor.
package dnsa_pkg;

  // Bytes of a packet that are parsed; later bytes are dropped until the end mark.
  localparam int unsigned MaxBytes  = 1024;
  localparam int unsigned OffWidth  = $clog2(MaxBytes + 1);

  // Header layout.
  localparam int unsigned HdrBytes     = 12;
  localparam int unsigned HdrRcodeOff  = 3;
  localparam int unsigned HdrAnCntHi   = 6;
  localparam int unsigned HdrAnCntLo   = 7;
  localparam int unsigned HdrLastOff   = 11;

  // Name and record layout.
  localparam logic [7:0]  PtrMask      = 8'hC0;
  localparam logic [7:0]  RcodeMask    = 8'h0F;
  localparam logic [3:0]  QFixLen      = 4'd4;
  localparam logic [3:0]  AFixLen      = 4'd10;
  localparam logic [3:0]  AFixTypeHi   = 4'd0;
  localparam logic [3:0]  AFixTypeLo   = 4'd1;
  localparam logic [3:0]  AFixRdlenHi  = 4'd8;
  localparam logic [3:0]  AFixRdlenLo  = 4'd9;
  localparam logic [3:0]  AddrLen      = 4'd4;
  localparam logic [15:0] TypeA        = 16'd1;
  localparam logic [15:0] RdlenA       = 16'd4;

  // Result width on the output stream, padded to whole bytes.
  localparam int unsigned ResWidth  = 36;
  localparam int unsigned OutWidth  = 40;

  // Parser phases, one-hot.
  typedef enum logic [11:0] {
    PH_HDR    = 12'b0000_0000_0001,
    PH_QLEN   = 12'b0000_0000_0010,
    PH_QLABEL = 12'b0000_0000_0100,
    PH_QPTR   = 12'b0000_0000_1000,
    PH_QFIX   = 12'b0000_0001_0000,
    PH_ALEN   = 12'b0000_0010_0000,
    PH_ALABEL = 12'b0000_0100_0000,
    PH_APTR   = 12'b0000_1000_0000,
    PH_AFIX   = 12'b0001_0000_0000,
    PH_RDSKIP = 12'b0010_0000_0000,
    PH_ADDR   = 12'b0100_0000_0000,
    PH_DONE   = 12'b1000_0000_0000
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_RCODE  = 3'd2,
    ST_QTRUNC = 3'd3,
    ST_NOA    = 3'd4
  } status_e;

  // One result; found sits in the lowest bit.
  typedef struct packed {
    status_e     status;
    logic [31:0] address;
    logic        found;
  } result_t;

endpackage

// ===== hw/rtl/dns_response_a_record_extractor.sv =====
// DNS response parser that extracts the first IPv4 A-record address of a packet.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] response byte, tlast marks the final byte
//  m_axis    out        tdata[0] found, [32:1] address, [35:33] status, [39:36] zero
//
// One byte is taken per clock unless the stall below holds it: the byte enters an
// input register and the parser state is updated from it, and for a final byte
// the result is loaded from there into the output register. The only stall is a
// final byte meeting a result that still waits in the output register. Reset
// clears the parser to the header phase and empties both registers.
module dns_response_a_record_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // found, address[31:0], status[2:0], zero pad
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state.
  logic [dnsa_pkg::OffWidth-1:0] byte_offset_q, byte_offset_d;
  dnsa_pkg::phase_e              phase_q, phase_d;
  logic [15:0]                   skip_count_q, skip_count_d;
  logic [15:0]                   answers_left_q, answers_left_d;
  logic [3:0]                    fix_idx_q, fix_idx_d;
  logic [15:0]                   record_type_q, record_type_d;
  logic [15:0]                   rdata_length_q, rdata_length_d;
  logic [31:0]                   address_q, address_d;
  logic                          error_q, error_d;
  logic                          held_q, held_d;

  // Output register.
  logic                          out_valid_q;
  dnsa_pkg::result_t             out_res_q;
  dnsa_pkg::result_t             res_d;

  logic                          advance;
  logic                          take;
  logic [15:0]                   skip_dec;
  logic [15:0]                   answers_dec;
  logic [3:0]                    fix_inc;
  logic [15:0]                   rdlen_new;
  dnsa_pkg::status_e             status;

  // The parse stage moves unless a final byte would overwrite a waiting result.
  assign advance = !(in_valid_q && in_last_q && out_valid_q && !m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign skip_dec    = skip_count_q - 16'd1;
  assign answers_dec = answers_left_q - 16'd1;
  assign fix_inc     = fix_idx_q + 4'd1;
  assign rdlen_new   = {rdata_length_q[15:8], in_byte_q};

  // Byte-by-byte parser step.
  always_comb begin
    byte_offset_d  = byte_offset_q;
    phase_d        = phase_q;
    skip_count_d   = skip_count_q;
    answers_left_d = answers_left_q;
    fix_idx_d      = fix_idx_q;
    record_type_d  = record_type_q;
    rdata_length_d = rdata_length_q;
    address_d      = address_q;
    error_d        = error_q;
    held_d         = held_q;
    if (byte_offset_q < dnsa_pkg::OffWidth'(dnsa_pkg::MaxBytes)) begin
      byte_offset_d = byte_offset_q + dnsa_pkg::OffWidth'(1);
      case (phase_q)
        dnsa_pkg::PH_HDR: begin
          if (byte_offset_q == dnsa_pkg::OffWidth'(dnsa_pkg::HdrRcodeOff) &&
              (in_byte_q & dnsa_pkg::RcodeMask) != 8'd0) begin
            error_d = 1'b1;
            phase_d = dnsa_pkg::PH_DONE;
          end else begin
            if (byte_offset_q == dnsa_pkg::OffWidth'(dnsa_pkg::HdrAnCntHi)) begin
              answers_left_d = {in_byte_q, 8'd0};
            end
            if (byte_offset_q == dnsa_pkg::OffWidth'(dnsa_pkg::HdrAnCntLo)) begin
              answers_left_d = {answers_left_q[15:8], in_byte_q};
            end
            if (byte_offset_q == dnsa_pkg::OffWidth'(dnsa_pkg::HdrLastOff)) begin
              phase_d = dnsa_pkg::PH_QLEN;
            end
          end
        end
        dnsa_pkg::PH_QLEN, dnsa_pkg::PH_ALEN: begin
          if (in_byte_q == 8'd0) begin
            phase_d   = (phase_q == dnsa_pkg::PH_ALEN) ? dnsa_pkg::PH_AFIX
                                                       : dnsa_pkg::PH_QFIX;
            fix_idx_d = 4'd0;
          end else if ((in_byte_q & dnsa_pkg::PtrMask) == dnsa_pkg::PtrMask) begin
            phase_d = (phase_q == dnsa_pkg::PH_ALEN) ? dnsa_pkg::PH_APTR
                                                     : dnsa_pkg::PH_QPTR;
          end else begin
            skip_count_d = {8'd0, in_byte_q};
            phase_d      = (phase_q == dnsa_pkg::PH_ALEN) ? dnsa_pkg::PH_ALABEL
                                                          : dnsa_pkg::PH_QLABEL;
          end
        end
        dnsa_pkg::PH_QLABEL: begin
          skip_count_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_d = dnsa_pkg::PH_QLEN;
          end
        end
        dnsa_pkg::PH_ALABEL: begin
          skip_count_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_d = dnsa_pkg::PH_ALEN;
          end
        end
        dnsa_pkg::PH_QPTR: begin
          phase_d   = dnsa_pkg::PH_QFIX;
          fix_idx_d = 4'd0;
        end
        dnsa_pkg::PH_APTR: begin
          phase_d   = dnsa_pkg::PH_AFIX;
          fix_idx_d = 4'd0;
        end
        dnsa_pkg::PH_QFIX: begin
          fix_idx_d = fix_inc;
          if (fix_inc >= dnsa_pkg::QFixLen) begin
            fix_idx_d = 4'd0;
            phase_d   = (answers_left_q == 16'd0) ? dnsa_pkg::PH_DONE : dnsa_pkg::PH_ALEN;
          end
        end
        dnsa_pkg::PH_AFIX: begin
          if (fix_idx_q == dnsa_pkg::AFixTypeHi) begin
            record_type_d = {in_byte_q, 8'd0};
          end
          if (fix_idx_q == dnsa_pkg::AFixTypeLo) begin
            record_type_d = {record_type_q[15:8], in_byte_q};
          end
          if (fix_idx_q == dnsa_pkg::AFixRdlenHi) begin
            rdata_length_d = {in_byte_q, 8'd0};
          end
          if (fix_idx_q == dnsa_pkg::AFixRdlenLo) begin
            rdata_length_d = rdlen_new;
          end
          fix_idx_d = fix_inc;
          // The last fixed byte completes the rdata length.
          if (fix_inc >= dnsa_pkg::AFixLen) begin
            fix_idx_d = 4'd0;
            if (record_type_q == dnsa_pkg::TypeA && rdlen_new == dnsa_pkg::RdlenA) begin
              phase_d   = dnsa_pkg::PH_ADDR;
              address_d = 32'd0;
            end else if (rdlen_new == 16'd0) begin
              answers_left_d = answers_dec;
              phase_d = (answers_dec == 16'd0) ? dnsa_pkg::PH_DONE : dnsa_pkg::PH_ALEN;
            end else begin
              skip_count_d = rdlen_new;
              phase_d      = dnsa_pkg::PH_RDSKIP;
            end
          end
        end
        dnsa_pkg::PH_RDSKIP: begin
          skip_count_d = skip_dec;
          if (skip_dec == 16'd0) begin
            answers_left_d = answers_dec;
            phase_d = (answers_dec == 16'd0) ? dnsa_pkg::PH_DONE : dnsa_pkg::PH_ALEN;
          end
        end
        dnsa_pkg::PH_ADDR: begin
          address_d = {address_q[23:0], in_byte_q};
          fix_idx_d = fix_inc;
          if (fix_inc >= dnsa_pkg::AddrLen) begin
            held_d  = 1'b1;
            phase_d = dnsa_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status of the packet as it stands after the current byte.
  always_comb begin
    if (byte_offset_d < dnsa_pkg::OffWidth'(dnsa_pkg::HdrBytes)) begin
      status = dnsa_pkg::ST_SHORT;
    end else if (error_d) begin
      status = dnsa_pkg::ST_RCODE;
    end else if (phase_d == dnsa_pkg::PH_QLEN || phase_d == dnsa_pkg::PH_QLABEL ||
                 phase_d == dnsa_pkg::PH_QPTR || phase_d == dnsa_pkg::PH_QFIX) begin
      status = dnsa_pkg::ST_QTRUNC;
    end else if (held_d) begin
      status = dnsa_pkg::ST_OK;
    end else begin
      status = dnsa_pkg::ST_NOA;
    end
    res_d.status  = status;
    res_d.found   = (status == dnsa_pkg::ST_OK);
    res_d.address = (status == dnsa_pkg::ST_OK) ? address_d : 32'd0;
  end

  // Parser state registers; the final byte returns them to the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q  <= '0;
      phase_q        <= dnsa_pkg::PH_HDR;
      skip_count_q   <= 16'd0;
      answers_left_q <= 16'd0;
      fix_idx_q      <= 4'd0;
      record_type_q  <= 16'd0;
      rdata_length_q <= 16'd0;
      address_q      <= 32'd0;
      error_q        <= 1'b0;
      held_q         <= 1'b0;
    end else if (take) begin
      if (in_last_q) begin
        byte_offset_q  <= '0;
        phase_q        <= dnsa_pkg::PH_HDR;
        skip_count_q   <= 16'd0;
        answers_left_q <= 16'd0;
        fix_idx_q      <= 4'd0;
        record_type_q  <= 16'd0;
        rdata_length_q <= 16'd0;
        address_q      <= 32'd0;
        error_q        <= 1'b0;
        held_q         <= 1'b0;
      end else begin
        byte_offset_q  <= byte_offset_d;
        phase_q        <= phase_d;
        skip_count_q   <= skip_count_d;
        answers_left_q <= answers_left_d;
        fix_idx_q      <= fix_idx_d;
        record_type_q  <= record_type_d;
        rdata_length_q <= rdata_length_d;
        address_q      <= address_d;
        error_q        <= error_d;
        held_q         <= held_d;
      end
    end
  end

  // Output register: loaded on a final byte, emptied by the downstream transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_last_q) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(dnsa_pkg::OutWidth - dnsa_pkg::ResWidth)'(0), out_res_q};

`ifndef SYNTHESIS
  // A stored result flags found exactly when its status is ok.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.found == (out_res_q.status == dnsa_pkg::ST_OK)))
    else $error("found flag disagrees with status");

  // A complete address or an rcode error ends the parse.
  a_held_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q || error_q) |-> (phase_q == dnsa_pkg::PH_DONE))
    else $error("parse continues after address or error");

  // The byte counter saturates at the packet size limit.
  a_offset_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_offset_q <= dnsa_pkg::OffWidth'(dnsa_pkg::MaxBytes))
    else $error("byte offset beyond limit");

  // A final byte that meets a waiting result never overwrites it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_res_q)))
    else $error("pending result lost");
`endif

endmodule
